// ----- rtl/ovy_pkg.sv -----
// Shared types and coefficient tables for the orthonormal YUV to VUYA converter.
`default_nettype none

package ovy_pkg;

  // Field widths
  localparam int COMP_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int COEF_W  = 17;
  localparam int COEF_FRAC = 16;
  localparam int PROD_W  = COMP_W + COEF_W;
  localparam int IN_DATA_W  = 3 * COMP_W + BYTE_W;
  localparam int OUT_DATA_W = 4 * BYTE_W;

  // One coefficient set: luma row (y, u, v), chroma U row (u, v), chroma V row (u, v)
  typedef struct packed {
    logic signed [COEF_W-1:0] ky;
    logic signed [COEF_W-1:0] kyu;
    logic signed [COEF_W-1:0] kyv;
    logic signed [COEF_W-1:0] kuu;
    logic signed [COEF_W-1:0] kuv;
    logic signed [COEF_W-1:0] kvu;
    logic signed [COEF_W-1:0] kvv;
  } coef_set_t;

  localparam coef_set_t COEF_BT601 = '{
    ky:  17'sd37837, kyu: 17'sd8573,  kyv: -17'sd20361,
    kuu: -17'sd30990, kuv: 17'sd26589,
    kvu: 17'sd26939,  kvv: 17'sd33606
  };

  localparam coef_set_t COEF_BT709 = '{
    ky:  17'sd37837, kyu: 17'sd6506,  kyv: -17'sd30650,
    kuu: -17'sd28480, kuv: 17'sd30936,
    kvu: 17'sd25295,  kvv: 17'sd36453
  };

  // Registered partial products of the first stage
  typedef struct packed {
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] yu;
    logic signed [PROD_W-1:0] yv;
    logic signed [PROD_W-1:0] uu;
    logic signed [PROD_W-1:0] uv;
    logic signed [PROD_W-1:0] vu;
    logic signed [PROD_W-1:0] vv;
  } prod_t;

endpackage

`default_nettype wire

// ----- rtl/orthonormal_yuv_to_vuya8.sv -----
// Top level: pipelined orthonormal YUV to 8-bit VUYA pixel converter.
`default_nettype none

// Converts one pixel per clock from signed orthonormal Y, U, V (INPUT_FRAC_BITS
// fractional bits) plus alpha into Y, U, V, A bytes, using BT.601 or BT.709
// coefficients as selected by the one-bit configuration word. Three register
// stages lie between input acceptance and a valid output word: one stage of seven
// 16x17 multipliers, one stage of three-term adds with offset and rounding
// bias, and one stage of round-half-up and saturation into the output register.
// Throughput is one pixel per clock; the whole pipeline holds while the output
// word waits, and s_axis_tready follows that hold. Write the configuration only
// while the pipeline is empty.
module orthonormal_yuv_to_vuya8 #(
  parameter int INPUT_FRAC_BITS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write: bit 0 = use_bt709
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_data,
  // Input pixel
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: luma_in[15:0], chroma_u_in[31:16], chroma_v_in[47:32], alpha_in[55:48]
  input  wire logic [ovy_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // Output pixel
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: luma_out[7:0], chroma_u_out[15:8], chroma_v_out[23:16], alpha_out[31:24]
  output logic [ovy_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  import ovy_pkg::*;

  localparam int TOTAL_FRAC = COEF_FRAC + INPUT_FRAC_BITS;
  localparam int ACC_W      = PROD_W + 3 + (INPUT_FRAC_BITS + 1) / 2;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS  = ACC_W'(1) << (TOTAL_FRAC - 1);
  localparam logic signed [ACC_W-1:0] CHROMA_BIAS =
    (ACC_W'(128) << TOTAL_FRAC) + ROUND_BIAS;

  // Round half up (bias already added) and clamp to 0..255
  function automatic logic [BYTE_W-1:0] sat8(input logic signed [ACC_W-1:0] s);
    logic [ACC_W-1:0] q;
    q = ACC_W'($unsigned(s) >> TOTAL_FRAC);
    if (s[ACC_W-1]) begin
      return '0;
    end else if (q > ACC_W'(255)) begin
      return '1;
    end else begin
      return q[BYTE_W-1:0];
    end
  endfunction

  logic use_bt709;
  logic adv;

  logic                     v1;
  prod_t                    prod1;
  logic [BYTE_W-1:0]        alpha1;

  logic                     v2;
  logic signed [ACC_W-1:0]  acc_y2;
  logic signed [ACC_W-1:0]  acc_u2;
  logic signed [ACC_W-1:0]  acc_v2;
  logic [BYTE_W-1:0]        alpha2;

  logic                     v3;
  logic [OUT_DATA_W-1:0]    data3;

  logic signed [COMP_W-1:0] y_in;
  logic signed [COMP_W-1:0] u_in;
  logic signed [COMP_W-1:0] v_in;
  coef_set_t                k;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_bt709 <= 1'b0;
    end else if (cfg_valid) begin
      use_bt709 <= cfg_data;
    end
  end

  // Whole pipeline advances unless the output word is stalled
  assign adv           = !v3 || m_axis_tready;
  assign s_axis_tready = adv;

  assign y_in = s_axis_tdata[COMP_W-1:0];
  assign u_in = s_axis_tdata[2*COMP_W-1:COMP_W];
  assign v_in = s_axis_tdata[3*COMP_W-1:2*COMP_W];
  assign k    = use_bt709 ? COEF_BT709 : COEF_BT601;

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      prod1.yy <= PROD_W'(y_in) * PROD_W'(k.ky);
      prod1.yu <= PROD_W'(u_in) * PROD_W'(k.kyu);
      prod1.yv <= PROD_W'(v_in) * PROD_W'(k.kyv);
      prod1.uu <= PROD_W'(u_in) * PROD_W'(k.kuu);
      prod1.uv <= PROD_W'(v_in) * PROD_W'(k.kuv);
      prod1.vu <= PROD_W'(u_in) * PROD_W'(k.kvu);
      prod1.vv <= PROD_W'(v_in) * PROD_W'(k.kvv);
      alpha1   <= s_axis_tdata[IN_DATA_W-1:3*COMP_W];
    end
  end

  // Stage 2: sum each row, add chroma offset and rounding bias
  always_ff @(posedge clk) begin
    if (adv) begin
      acc_y2 <= ACC_W'(prod1.yy) + ACC_W'(prod1.yu) + ACC_W'(prod1.yv) + ROUND_BIAS;
      acc_u2 <= ACC_W'(prod1.uu) + ACC_W'(prod1.uv) + CHROMA_BIAS;
      acc_v2 <= ACC_W'(prod1.vu) + ACC_W'(prod1.vv) + CHROMA_BIAS;
      alpha2 <= alpha1;
    end
  end

  // Stage 3: saturate into the output word
  always_ff @(posedge clk) begin
    if (adv) begin
      data3 <= {alpha2, sat8(acc_v2), sat8(acc_u2), sat8(acc_y2)};
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = data3;

`ifndef SYNTHESIS
  // An accepted word occupies the first stage on the next clock
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted word missing from first stage");

  // A stalled pipeline keeps every valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v1) && $stable(v2) && $stable(v3))
    else $error("pipeline changed while stalled");

  // Output valid only rises behind a valid second stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(v2))
    else $error("output word without a source");
`endif

endmodule

`default_nettype wire

// ----- test/ovy_checker.sv -----
// Checker for the orthonormal YUV to VUYA converter: watches the channels, predicts each pixel.
`timescale 1ns / 1ps

module ovy_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic                          cfg_data,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  // tdata: luma_in[15:0], chroma_u_in[31:16], chroma_v_in[47:32], alpha_in[55:48]
  input  wire logic [ovy_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: luma_out[7:0], chroma_u_out[15:8], chroma_v_out[23:16], alpha_out[31:24]
  input  wire logic [ovy_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                                 mismatches,
  output int                                 outstanding,
  output int                                 checked
);

  // 16 coefficient fraction bits plus 4 input fraction bits
  localparam int ACC_FRAC = 20;

  // Output word layout, luma in the lowest byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] cv;
    logic [7:0] cu;
    logic [7:0] luma;
  } vuya_t;

  vuya_t expected_pixels[$];
  logic  bt709_sel;
  int    fail_n = 0;
  int    match_n = 0;

  // Round half up, then clamp to one byte
  function automatic logic [7:0] round_clamp(longint acc);
    longint biased;
    biased = acc + (longint'(1) << (ACC_FRAC - 1));
    if (biased < 0) return 8'd0;
    biased = biased >>> ACC_FRAC;
    return (biased > 255) ? 8'd255 : biased[7:0];
  endfunction

  // Inverse orthonormal matrix for one pixel
  function automatic vuya_t convert_pixel(logic [ovy_pkg::IN_DATA_W-1:0] d, logic sel);
    longint y, u, v, chroma_off;
    longint ky, kyu, kyv, kuu, kuv, kvu, kvv;
    vuya_t p;
    y = $signed(d[15:0]);
    u = $signed(d[31:16]);
    v = $signed(d[47:32]);
    ky = 37837;
    if (sel) begin
      kyu = 6506;   kyv = -30650;
      kuu = -28480; kuv = 30936;
      kvu = 25295;  kvv = 36453;
    end else begin
      kyu = 8573;   kyv = -20361;
      kuu = -30990; kuv = 26589;
      kvu = 26939;  kvv = 33606;
    end
    chroma_off = longint'(128) << ACC_FRAC;
    p.luma  = round_clamp(ky * y + kyu * u + kyv * v);
    p.cu    = round_clamp(kuu * u + kuv * v + chroma_off);
    p.cv    = round_clamp(kvu * u + kvv * v + chroma_off);
    p.alpha = d[55:48];
    return p;
  endfunction

  // Track the coefficient select, queue predictions, compare output words
  always @(posedge clk) begin : watch
    vuya_t want;
    vuya_t got;
    if (rst) begin
      bt709_sel = 1'b0;
      expected_pixels.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          $error("output word %h with no pixel pending", m_axis_tdata);
          fail_n++;
        end else begin
          want = expected_pixels.pop_front();
          match_n++;
          if (got.luma !== want.luma) begin
            $error("luma_out: expected %0d, got %0d", want.luma, got.luma);
            fail_n++;
          end
          if (got.cu !== want.cu) begin
            $error("chroma_u_out: expected %0d, got %0d", want.cu, got.cu);
            fail_n++;
          end
          if (got.cv !== want.cv) begin
            $error("chroma_v_out: expected %0d, got %0d", want.cv, got.cv);
            fail_n++;
          end
          if (got.alpha !== want.alpha) begin
            $error("alpha_out: expected %0d, got %0d", want.alpha, got.alpha);
            fail_n++;
          end
        end
      end
      // A word taken at the same edge as a select write still sees the old select
      if (s_axis_tvalid && s_axis_tready)
        expected_pixels.push_back(convert_pixel(s_axis_tdata, bt709_sel));
      if (cfg_valid && cfg_ready) bt709_sel = cfg_data;
    end
    mismatches  <= fail_n;
    outstanding <= expected_pixels.size();
    checked     <= match_n;
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the orthonormal YUV to VUYA converter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_data = 1'b0;
  logic cfg_ready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ovy_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ovy_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int checked;
  int cycle_count = 0;
  int cfg_writes = 0;
  int long_holds = 0;
  bit no_gaps = 1'b0;
  bit long_hold_req = 1'b0;

  always #6 clk = ~clk;

  orthonormal_yuv_to_vuya8 uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  ovy_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .mismatches(mismatches), .outstanding(outstanding), .checked(checked)
  );

  // Bound the run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d pixels still pending", cycle_count, outstanding);
    $display("orthonormal_yuv_to_vuya8 verification failed");
    $finish;
  end

  // Pack one pixel word, luma in the lowest bits
  function automatic logic [ovy_pkg::IN_DATA_W-1:0] pixel(logic [15:0] y, logic [15:0] u,
                                                          logic [15:0] v, logic [7:0] a);
    return {a, v, u, y};
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_pixel(logic [ovy_pkg::IN_DATA_W-1:0] word);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every predicted pixel has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write the coefficient select with the pipeline empty
  task automatic write_select(logic sel);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Random pixels: mostly in-gamut values, some full-range noise, some near clip points
  task automatic random_phase(int n, bit with_hold);
    int kind;
    int y, u, v;
    for (int i = 0; i < n; i++) begin
      if (i % 80 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (with_hold && i == 20) begin
        long_hold_req = 1'b1;
        no_gaps = 1'b1;
      end
      if (i == n / 2) drain();
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        y = int'($urandom_range(0, 7200)) - 100;
        u = int'($urandom_range(0, 8000)) - 4000;
        v = int'($urandom_range(0, 8000)) - 4000;
      end else if (kind < 8) begin
        y = $urandom;
        u = $urandom;
        v = $urandom;
      end else begin
        y = $urandom_range(0, 1) ? int'($urandom_range(7000, 7140))
                                 : int'($urandom_range(0, 120)) - 60;
        u = int'($urandom_range(0, 9000)) - 4500;
        v = int'($urandom_range(0, 9000)) - 4500;
      end
      send_pixel(pixel(y[15:0], u[15:0], v[15:0], 8'($urandom_range(0, 255))));
    end
  endtask

  // Output side: random stalls, bursts of steady ready, one long hold on request
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        long_holds++;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    longint num;
    longint half_u;
    longint half_v;
    bit found;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels under the reset select (BT.601)
    send_pixel(pixel(16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_pixel(pixel(16'h7fff, 16'h7fff, 16'h7fff, 8'hff));
    send_pixel(pixel(16'h8000, 16'h8000, 16'h8000, 8'h00));
    send_pixel(pixel(16'h7fff, 16'h8000, 16'h7fff, 8'ha5));
    send_pixel(pixel(16'h8000, 16'h7fff, 16'h8000, 8'h5a));
    // small negative luma rounds to zero, larger negative clips
    send_pixel(pixel(16'hffff, 16'h0000, 16'h0000, 8'h01));
    send_pixel(pixel(16'hfff2, 16'h0000, 16'h0000, 8'h02));
    // luma just under and just over one half
    send_pixel(pixel(16'd13, 16'h0000, 16'h0000, 8'h80));
    send_pixel(pixel(16'd14, 16'h0000, 16'h0000, 8'h7f));
    // luma just under and just over the 254.5 clip point
    send_pixel(pixel(16'd7052, 16'h0000, 16'h0000, 8'h40));
    send_pixel(pixel(16'd7053, 16'h0000, 16'h0000, 8'h20));
    // chroma one unit each way, unit chroma on luma
    send_pixel(pixel(16'd16, 16'd16, 16'h0000, 8'h10));
    send_pixel(pixel(16'd16, 16'h0000, 16'hfff0, 8'h08));
    send_pixel(pixel(16'h0000, 16'hfff0, 16'd16, 8'h04));

    // Find a pixel whose U channel lands exactly on 129.5 and must round up
    found = 1'b0;
    half_u = 0;
    half_v = 0;
    for (longint vv = -32768; vv <= 32767 && !found; vv++) begin
      num = 26589 * vv - 1572864;
      if (num % 30990 == 0 && num / 30990 >= -32768 && num / 30990 <= 32767) begin
        half_u = num / 30990;
        half_v = vv;
        found = 1'b1;
      end
    end
    send_pixel(pixel(16'h0000, half_u[15:0], half_v[15:0], 8'hc3));

    random_phase(PHASE_ITEMS, 1'b0);
    write_select(1'b1);
    random_phase(PHASE_ITEMS, 1'b1);
    write_select(1'b0);
    random_phase(PHASE_ITEMS, 1'b0);
    write_select(1'b1);
    random_phase(PHASE_ITEMS, 1'b0);

    drain();
    repeat (10) @(posedge clk);

    $display("Checked %0d pixels: directed extremes, rounding and clip points, then random",
             checked);
    $display("Coefficient select written %0d times (BT.601 and BT.709), %0d long output holds",
             cfg_writes, long_holds);
    if (mismatches == 0) begin
      $display("orthonormal_yuv_to_vuya8 verification clean");
    end else begin
      $display("orthonormal_yuv_to_vuya8 verification failed");
    end
    $finish;
  end

endmodule
